[hdl/bmi_pkg.sv]
`default_nettype none
package bmi_pkg;

  // inversion mode, decided when an item is accepted
  typedef enum logic [1:0] {
    MODE_FULL,
    MODE_SLAB,
    MODE_DIAG,
    MODE_NONE
  } mode_e;

  // periodicity codes
  localparam logic [2:0] PER_NONE    = 3'd0;
  localparam logic [2:0] PER_LINE    = 3'd1;
  localparam logic [2:0] PER_SLAB    = 3'd2;
  localparam logic [2:0] PER_FULL    = 3'd3;
  localparam logic [2:0] PER_CLUSTER = 3'd4;
  localparam logic [2:0] PER_RESET   = PER_FULL;

  // determinant output format
  localparam int DET_W    = 64;
  localparam int DET_FRAC = 24;

  // matrix entry indexes, row major
  localparam logic [3:0] E11 = 4'd0;
  localparam logic [3:0] E12 = 4'd1;
  localparam logic [3:0] E13 = 4'd2;
  localparam logic [3:0] E21 = 4'd3;
  localparam logic [3:0] E22 = 4'd4;
  localparam logic [3:0] E23 = 4'd5;
  localparam logic [3:0] E31 = 4'd6;
  localparam logic [3:0] E32 = 4'd7;
  localparam logic [3:0] E33 = 4'd8;
  localparam int         N_ENTRY    = 9;
  localparam logic [3:0] LAST_ENTRY = E33;

  // multiply operand sources and destinations
  typedef enum logic [1:0] {
    BSRC_M,
    BSRC_NUM,
    BSRC_TMP
  } bsrc_e;

  typedef enum logic [1:0] {
    DST_NUM,
    DST_TMP,
    DST_DET
  } dst_e;

  // one multiply-accumulate step of the back end
  typedef struct packed {
    logic [3:0] a;
    bsrc_e      bsrc;
    logic [3:0] b;
    logic       sub;
    logic       first;
    logic       last;
    dst_e       dst;
    logic [3:0] k;
  } mop_t;

  // queue head status seen by the back end
  typedef struct packed {
    logic  valid;
    mode_e mode;
  } item_ctl_t;

  localparam logic [4:0] COF_OPS   = 5'd18;
  localparam logic [4:0] LAST_FULL = 5'd20;
  localparam logic [4:0] LAST_SLAB = 5'd2;
  localparam logic [4:0] LAST_DIAG = 5'd1;

  // cofactor k = a*b - c*d
  localparam logic [3:0] COF_IDX [9][4] = '{
    '{E22, E33, E23, E32},
    '{E13, E32, E12, E33},
    '{E12, E23, E13, E22},
    '{E23, E31, E21, E33},
    '{E11, E33, E13, E31},
    '{E13, E21, E11, E23},
    '{E21, E32, E22, E31},
    '{E12, E31, E11, E32},
    '{E11, E22, E12, E21}
  };

  // determinant as expansion along the first row
  localparam logic [3:0] DET_A [3] = '{E11, E12, E13};
  localparam logic [3:0] DET_B [3] = '{E11, E21, E31};

  function automatic mop_t get_op(mode_e mode, logic [4:0] step);
    mop_t       op;
    logic [3:0] k;
    logic [1:0] j;
    op = '0;
    k  = step[4:1];
    j  = 2'(step - COF_OPS);
    case (mode)
      MODE_FULL: begin
        if (step < COF_OPS) begin
          op.bsrc = BSRC_M;
          op.k    = k;
          op.dst  = DST_NUM;
          if (!step[0]) begin
            op.a     = COF_IDX[k][0];
            op.b     = COF_IDX[k][1];
            op.first = 1'b1;
          end else begin
            op.a    = COF_IDX[k][2];
            op.b    = COF_IDX[k][3];
            op.sub  = 1'b1;
            op.last = 1'b1;
          end
        end else begin
          op.a     = DET_A[j];
          op.bsrc  = BSRC_NUM;
          op.b     = DET_B[j];
          op.first = (j == 2'd0);
          op.last  = (j == 2'd2);
          op.dst   = DST_DET;
        end
      end
      MODE_SLAB: begin
        case (step)
          5'd0: begin
            op.a = E11; op.bsrc = BSRC_M; op.b = E22; op.first = 1'b1;
          end
          5'd1: begin
            op.a = E12; op.bsrc = BSRC_M; op.b = E21; op.sub = 1'b1;
            op.last = 1'b1; op.dst = DST_TMP;
          end
          default: begin
            op.a = E33; op.bsrc = BSRC_TMP; op.first = 1'b1;
            op.last = 1'b1; op.dst = DST_DET;
          end
        endcase
      end
      MODE_DIAG: begin
        if (step == 5'd0) begin
          op.a = E11; op.bsrc = BSRC_M; op.b = E22; op.first = 1'b1;
          op.last = 1'b1; op.dst = DST_TMP;
        end else begin
          op.a = E33; op.bsrc = BSRC_TMP; op.first = 1'b1;
          op.last = 1'b1; op.dst = DST_DET;
        end
      end
      default: op = '0;
    endcase
    return op;
  endfunction

  function automatic logic [4:0] last_step(mode_e mode);
    case (mode)
      MODE_FULL: return LAST_FULL;
      MODE_SLAB: return LAST_SLAB;
      default:   return LAST_DIAG;
    endcase
  endfunction

  // matrix entry that feeds the numerator or denominator of entry k
  function automatic logic [3:0] div_src(mode_e mode, logic [3:0] k);
    if (mode == MODE_SLAB) begin
      case (k)
        E11:     return E22;
        E22:     return E11;
        default: return k;
      endcase
    end
    return k;
  endfunction

endpackage
`default_nettype wire

[hdl/bmi_front.sv]
`default_nettype none
module bmi_front #(
  parameter int DW = 32
) (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     start,
  output logic                          busy,
  input  wire logic signed [DW-1:0]     m_i [9],
  input  wire logic                     cfg_we_i,
  input  wire logic [2:0]               cfg_wdata_i,
  input  wire logic                     pop_i,
  output bmi_pkg::item_ctl_t            ctl_o,
  output logic [9*DW-1:0]               item_o
);

  localparam logic [1:0] DEPTH = 2'd2;

  logic [2:0]            per_q;
  logic [9*DW-1:0]       data_q [2];
  bmi_pkg::mode_e        mode_q [2];
  logic                  wr_ptr_q, rd_ptr_q;
  logic [1:0]            cnt_q;
  logic                  push;
  logic [9*DW-1:0]       packed_m;
  bmi_pkg::mode_e        mode_cls;

  // classify the item by the periodicity register
  always_comb begin
    case (per_q)
      bmi_pkg::PER_FULL:    mode_cls = bmi_pkg::MODE_FULL;
      bmi_pkg::PER_SLAB:    mode_cls = bmi_pkg::MODE_SLAB;
      bmi_pkg::PER_NONE,
      bmi_pkg::PER_LINE,
      bmi_pkg::PER_CLUSTER: mode_cls = bmi_pkg::MODE_DIAG;
      default:              mode_cls = bmi_pkg::MODE_NONE;
    endcase
  end

  // pack the nine entries
  always_comb begin
    for (int i = 0; i < 9; i++) begin
      packed_m[i*DW +: DW] = m_i[i];
    end
  end

  assign busy  = (cnt_q == DEPTH);
  assign push  = start && !busy;
  assign ctl_o = '{valid: (cnt_q != 2'd0), mode: mode_q[rd_ptr_q]};
  assign item_o = data_q[rd_ptr_q];

  // config register and queue pointers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      per_q    <= bmi_pkg::PER_RESET;
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (cfg_we_i) begin
        per_q <= cfg_wdata_i;
      end
      if (push) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (pop_i) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
      cnt_q <= cnt_q + 2'(push) - 2'(pop_i);
    end
  end

  // queue storage
  always_ff @(posedge clk_i) begin
    if (push) begin
      data_q[wr_ptr_q] <= packed_m;
      mode_q[wr_ptr_q] <= mode_cls;
    end
  end

  a_pop_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> (cnt_q != 2'd0))
    else $error("queue popped while empty");

endmodule
`default_nettype wire

[hdl/bmi_back.sv]
`default_nettype none
module bmi_back #(
  parameter int DW = 32,
  parameter int F  = 16
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire bmi_pkg::item_ctl_t   ctl_i,
  input  wire logic [9*DW-1:0]      item_i,
  output logic                      pop_o,
  output logic                      done_o,
  output logic signed [DW-1:0]      inv_o [9],
  output logic signed [63:0]        det_o,
  output logic                      zero_o
);

  localparam int BW  = 2*DW + 2;
  localparam int AW  = 3*DW + 2;
  localparam int NW  = BW + 2*F;
  localparam int QW  = DW + 1;
  localparam int CW  = $clog2(NW);
  localparam int DSH = 3*F - bmi_pkg::DET_FRAC;
  localparam int EW  = (AW > bmi_pkg::DET_W + 1) ? AW : bmi_pkg::DET_W + 1;
  localparam logic signed [BW-1:0] NUM_ONE = BW'(1);
  localparam logic [QW-1:0] HALF = QW'(1) << (DW-1);
  localparam logic [EW-1:0] DHALF = EW'(1) << (bmi_pkg::DET_W-1);

  typedef enum logic [3:0] {
    S_IDLE, S_FILL, S_FETCH, S_MSET, S_MUL, S_CHK, S_DFETCH, S_DSET, S_DIV, S_DONE
  } state_e;

  state_e                state_q;
  logic [4:0]            step_q;
  logic [3:0]            k_q;
  logic [CW-1:0]         cnt_q;
  bmi_pkg::mode_e        mode_q;
  logic                  done_q;

  logic signed [DW-1:0]  m_q [9];
  logic signed [BW-1:0]  num_q [9];
  logic signed [BW-1:0]  tmp_q;
  logic signed [AW-1:0]  det_q, acc_q;
  logic [DW-1:0]         amag_q;
  logic [AW-1:0]         bsh_q;
  logic                  neg_q;
  logic signed [DW-1:0]  ra_q, rbm_q;
  logic signed [BW-1:0]  rbn_q;
  logic [NW-1:0]         nsh_q;
  logic [AW-1:0]         rem_q, dmag_q;
  logic [QW-1:0]         quo_q;
  logic                  ovf_q, qneg_q, zden_q;
  logic signed [DW-1:0]  inv_q [9];
  logic signed [DW-1:0]  inv_out_q [9];
  logic signed [63:0]    det_out_q;
  logic                  zero_q;

  bmi_pkg::mop_t         op;
  logic                  mul_last, div_last;
  logic signed [BW-1:0]  bval;
  logic [BW-1:0]         bmag;
  logic [DW-1:0]         amag;
  logic signed [AW-1:0]  acc_fin;
  logic [AW:0]           r2;
  logic                  ge;
  logic [AW-1:0]         rem_nxt;
  logic [QW-1:0]         quo_nxt;
  logic                  ovf_nxt;
  logic signed [DW-1:0]  inv_val;
  logic signed [BW-1:0]  nsel;
  logic signed [AW-1:0]  dsel;
  logic [BW-1:0]         nmag;
  logic [AW-1:0]         dabs_sel, dabs;
  logic [EW-1:0]         dsh;
  logic signed [63:0]    det_val;
  logic                  flag;

  assign op       = bmi_pkg::get_op(mode_q, step_q);
  assign mul_last = (cnt_q == CW'(DW-1));
  assign div_last = (cnt_q == CW'(NW-1));
  assign pop_o    = (state_q == S_FILL) && (k_q == bmi_pkg::LAST_ENTRY);

  // multiplier operands, sign and magnitude
  always_comb begin
    case (op.bsrc)
      bmi_pkg::BSRC_M:   bval = BW'(rbm_q);
      bmi_pkg::BSRC_NUM: bval = rbn_q;
      bmi_pkg::BSRC_TMP: bval = tmp_q;
      default:           bval = '0;
    endcase
    bmag = bval[BW-1] ? BW'(-bval) : BW'(bval);
    amag = ra_q[DW-1] ? DW'(-ra_q) : DW'(ra_q);
  end

  // shift-add step
  always_comb begin
    if (!amag_q[0]) begin
      acc_fin = acc_q;
    end else if (neg_q) begin
      acc_fin = acc_q - signed'(bsh_q);
    end else begin
      acc_fin = acc_q + signed'(bsh_q);
    end
  end

  // restoring division step and saturation
  always_comb begin
    r2      = {rem_q, nsh_q[NW-1]};
    ge      = (r2 >= {1'b0, dmag_q});
    rem_nxt = ge ? AW'(r2 - {1'b0, dmag_q}) : r2[AW-1:0];
    quo_nxt = {quo_q[QW-2:0], ge};
    ovf_nxt = ovf_q | quo_q[QW-1];
    if (!qneg_q) begin
      if (ovf_nxt || quo_nxt > HALF - QW'(1)) inv_val = {1'b0, {(DW-1){1'b1}}};
      else                                    inv_val = quo_nxt[DW-1:0];
    end else begin
      if (ovf_nxt || quo_nxt > HALF) inv_val = {1'b1, {(DW-1){1'b0}}};
      else                           inv_val = -quo_nxt[DW-1:0];
    end
  end

  // numerator and denominator of entry k
  always_comb begin
    nsel = '0;
    dsel = '0;
    case (mode_q)
      bmi_pkg::MODE_FULL: begin
        nsel = rbn_q;
        dsel = det_q;
      end
      bmi_pkg::MODE_SLAB: begin
        if (k_q == bmi_pkg::E11 || k_q == bmi_pkg::E22) begin
          nsel = BW'(rbm_q);
          dsel = AW'(tmp_q);
        end else if (k_q == bmi_pkg::E12 || k_q == bmi_pkg::E21) begin
          nsel = -BW'(rbm_q);
          dsel = AW'(tmp_q);
        end else if (k_q == bmi_pkg::E33) begin
          nsel = NUM_ONE;
          dsel = AW'(rbm_q);
        end
      end
      bmi_pkg::MODE_DIAG: begin
        if (k_q == bmi_pkg::E11 || k_q == bmi_pkg::E22 || k_q == bmi_pkg::E33) begin
          nsel = NUM_ONE;
          dsel = AW'(rbm_q);
        end
      end
      default: begin
        nsel = '0;
        dsel = '0;
      end
    endcase
    nmag     = nsel[BW-1] ? BW'(-nsel) : BW'(nsel);
    dabs_sel = dsel[AW-1] ? AW'(-dsel) : AW'(dsel);
  end

  // determinant rescale and saturation
  always_comb begin
    dabs = det_q[AW-1] ? AW'(-det_q) : AW'(det_q);
    dsh  = EW'(dabs >> DSH);
    if (!det_q[AW-1]) begin
      if (dsh > DHALF - EW'(1)) det_val = {1'b0, {63{1'b1}}};
      else                      det_val = dsh[63:0];
    end else begin
      if (dsh > DHALF) det_val = {1'b1, {63{1'b0}}};
      else             det_val = -dsh[63:0];
    end
    flag = (mode_q == bmi_pkg::MODE_NONE) || (det_q == '0);
  end

  // sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      step_q  <= '0;
      k_q     <= '0;
      cnt_q   <= '0;
      mode_q  <= bmi_pkg::MODE_NONE;
      done_q  <= 1'b0;
    end else begin
      done_q <= 1'b0;
      case (state_q)
        S_IDLE: begin
          if (ctl_i.valid) begin
            k_q     <= '0;
            state_q <= S_FILL;
          end
        end
        S_FILL: begin
          if (k_q == bmi_pkg::LAST_ENTRY) begin
            mode_q  <= ctl_i.mode;
            step_q  <= '0;
            state_q <= (ctl_i.mode == bmi_pkg::MODE_NONE) ? S_DONE : S_FETCH;
          end else begin
            k_q <= k_q + 4'd1;
          end
        end
        S_FETCH: state_q <= S_MSET;
        S_MSET: begin
          cnt_q   <= '0;
          state_q <= S_MUL;
        end
        S_MUL: begin
          if (mul_last) begin
            if (step_q == bmi_pkg::last_step(mode_q)) begin
              state_q <= S_CHK;
            end else begin
              step_q  <= step_q + 5'd1;
              state_q <= S_FETCH;
            end
          end else begin
            cnt_q <= cnt_q + CW'(1);
          end
        end
        S_CHK: begin
          k_q     <= '0;
          state_q <= (det_q == '0) ? S_DONE : S_DFETCH;
        end
        S_DFETCH: state_q <= S_DSET;
        S_DSET: begin
          cnt_q   <= '0;
          state_q <= S_DIV;
        end
        S_DIV: begin
          if (div_last) begin
            if (k_q == bmi_pkg::LAST_ENTRY) begin
              state_q <= S_DONE;
            end else begin
              k_q     <= k_q + 4'd1;
              state_q <= S_DFETCH;
            end
          end else begin
            cnt_q <= cnt_q + CW'(1);
          end
        end
        S_DONE: begin
          done_q  <= 1'b1;
          state_q <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // datapath and operand stores
  always_ff @(posedge clk_i) begin
    case (state_q)
      S_FILL: m_q[k_q] <= item_i[k_q*DW +: DW];
      S_FETCH: begin
        ra_q  <= m_q[op.a];
        rbm_q <= m_q[op.b];
        rbn_q <= num_q[op.b];
      end
      S_MSET: begin
        amag_q <= amag;
        bsh_q  <= AW'(bmag);
        neg_q  <= ra_q[DW-1] ^ bval[BW-1] ^ op.sub;
        if (op.first) begin
          acc_q <= '0;
        end
      end
      S_MUL: begin
        acc_q  <= acc_fin;
        amag_q <= amag_q >> 1;
        bsh_q  <= bsh_q << 1;
        if (mul_last && op.last) begin
          case (op.dst)
            bmi_pkg::DST_NUM: num_q[op.k] <= BW'(acc_fin);
            bmi_pkg::DST_TMP: tmp_q       <= BW'(acc_fin);
            bmi_pkg::DST_DET: det_q       <= acc_fin;
            default:          det_q       <= acc_fin;
          endcase
        end
      end
      S_DFETCH: begin
        rbm_q <= m_q[bmi_pkg::div_src(mode_q, k_q)];
        rbn_q <= num_q[k_q];
      end
      S_DSET: begin
        nsh_q  <= {nmag, {(2*F){1'b0}}};
        dmag_q <= dabs_sel;
        qneg_q <= nsel[BW-1] ^ dsel[AW-1];
        zden_q <= (dsel == '0);
        rem_q  <= '0;
        quo_q  <= '0;
        ovf_q  <= 1'b0;
      end
      S_DIV: begin
        rem_q <= rem_nxt;
        nsh_q <= nsh_q << 1;
        quo_q <= quo_nxt;
        ovf_q <= ovf_nxt;
        if (div_last) begin
          inv_q[k_q] <= zden_q ? '0 : inv_val;
        end
      end
      S_DONE: begin
        for (int i = 0; i < 9; i++) begin
          inv_out_q[i] <= flag ? '0 : inv_q[i];
        end
        det_out_q <= flag ? '0 : det_val;
        zero_q    <= flag;
      end
      default: ;
    endcase
  end

  assign done_o = done_q;
  assign inv_o  = inv_out_q;
  assign det_o  = det_out_q;
  assign zero_o = zero_q;

  a_strobe_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o)
    else $error("result strobe longer than one cycle");

  a_zero_det: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && zero_o) |-> (det_o == '0))
    else $error("zero volume with nonzero determinant");

  a_pop_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o |-> ctl_i.valid)
    else $error("item taken from an empty queue");

endmodule
`default_nettype wire

[hdl/box_matrix_inverse_3x3.sv]
`default_nettype none
// Inverse and determinant of a 3x3 box matrix in signed fixed point. An item
// is taken when start is high and busy is low; a two-entry queue holds items
// while the sequencer works, and busy rises only when that queue is full.
// Each item runs through one shift-add multiplier and one restoring divider,
// one bit per cycle; the full, slab and diagonal modes take 21, 3 or 2
// multiply-accumulate steps. Periodicity codes without a mode skip the
// arithmetic. Each result is announced by done_o, high for a single cycle,
// and cannot be held off; the output ports keep it until the next result.
module box_matrix_inverse_3x3 #(
  parameter int DATA_WIDTH    = 32,
  parameter int FRACTION_BITS = 16
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         start,
  output logic                              busy,
  input  wire logic                         cfg_we_i,
  input  wire logic [2:0]                   cfg_wdata_i,
  input  wire logic signed [DATA_WIDTH-1:0] m11_i,
  input  wire logic signed [DATA_WIDTH-1:0] m12_i,
  input  wire logic signed [DATA_WIDTH-1:0] m13_i,
  input  wire logic signed [DATA_WIDTH-1:0] m21_i,
  input  wire logic signed [DATA_WIDTH-1:0] m22_i,
  input  wire logic signed [DATA_WIDTH-1:0] m23_i,
  input  wire logic signed [DATA_WIDTH-1:0] m31_i,
  input  wire logic signed [DATA_WIDTH-1:0] m32_i,
  input  wire logic signed [DATA_WIDTH-1:0] m33_i,
  output logic                              done_o,
  output logic signed [DATA_WIDTH-1:0]      inv11_o,
  output logic signed [DATA_WIDTH-1:0]      inv12_o,
  output logic signed [DATA_WIDTH-1:0]      inv13_o,
  output logic signed [DATA_WIDTH-1:0]      inv21_o,
  output logic signed [DATA_WIDTH-1:0]      inv22_o,
  output logic signed [DATA_WIDTH-1:0]      inv23_o,
  output logic signed [DATA_WIDTH-1:0]      inv31_o,
  output logic signed [DATA_WIDTH-1:0]      inv32_o,
  output logic signed [DATA_WIDTH-1:0]      inv33_o,
  output logic signed [63:0]                determinant_o,
  output logic                              zero_volume_o
);

  logic signed [DATA_WIDTH-1:0] m_in [9];
  logic signed [DATA_WIDTH-1:0] inv [9];
  bmi_pkg::item_ctl_t           ctl;
  logic [9*DATA_WIDTH-1:0]      item;
  logic                         pop;

  assign m_in = '{m11_i, m12_i, m13_i, m21_i, m22_i, m23_i, m31_i, m32_i, m33_i};

  // accept, classify and queue
  bmi_front #(.DW(DATA_WIDTH)) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .m_i         (m_in),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .pop_i       (pop),
    .ctl_o       (ctl),
    .item_o      (item)
  );

  // multiply, divide and deliver
  bmi_back #(.DW(DATA_WIDTH), .F(FRACTION_BITS)) u_back (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctl_i  (ctl),
    .item_i (item),
    .pop_o  (pop),
    .done_o (done_o),
    .inv_o  (inv),
    .det_o  (determinant_o),
    .zero_o (zero_volume_o)
  );

  assign inv11_o = inv[0];
  assign inv12_o = inv[1];
  assign inv13_o = inv[2];
  assign inv21_o = inv[3];
  assign inv22_o = inv[4];
  assign inv23_o = inv[5];
  assign inv31_o = inv[6];
  assign inv32_o = inv[7];
  assign inv33_o = inv[8];

endmodule
`default_nettype wire
